/* sv/lwm_pkg.sv */
// Shared types and constants for the LIKE wildcard matcher.
// Used by every module of the block; depends on nothing else.
package lwm_pkg;

    // Default pattern store depth.
    localparam int MAX_PATTERN_DEF = 32;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] CHAR_PERCENT    = 8'h25;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] ESC_CHAR_RESET  = 8'd92;

    // Configuration register indexes (word address bit 2).
    localparam logic REG_ESC_ENABLED = 1'b0;
    localparam logic REG_ESC_CHAR    = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_VALUE  = 2'd2,
        ACT_EMPTY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY_ONE = 2'd1,
        KIND_PERCENT = 2'd2
    } kind_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

endpackage

/* sv/lwm_pattern_store.sv */
// Pattern store: turns pattern bytes into elements, tracks count, escape and overflow.
// Also keeps the closed start position set. Depends on lwm_pkg.
module lwm_pattern_store
    import lwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  action_t               action,
    input  logic [7:0]            data_byte,
    input  logic                  esc_enabled,
    input  logic [7:0]            esc_char,
    output logic [MAX_PATTERN-1:0] pct_mask,
    output logic [MAX_PATTERN-1:0] any_mask,
    output logic [MAX_PATTERN-1:0] lit_mask,
    output logic [7:0]            elem_byte [MAX_PATTERN],
    output logic [$clog2(MAX_PATTERN+1)-1:0] count,
    output logic                  overflow,
    output logic [MAX_PATTERN:0]  start_set
);

    localparam int N  = MAX_PATTERN;
    localparam int CW = $clog2(N + 1);

    kind_t          kind_reg  [N];
    kind_t          kind_next [N];
    logic [7:0]     byte_reg  [N];
    logic [7:0]     byte_next [N];
    logic [CW-1:0]  count_reg, count_next;
    logic           esc_reg, esc_next;
    logic           ovf_reg, ovf_next;
    logic [N:0]     start_reg, start_next;

    logic           wr_en;
    logic [CW-1:0]  wr_sel;
    kind_t          wr_kind;
    logic [N-1:0]   pct_next;

    // A percent element reached at an active position also activates the next one.
    // The carries of (active & percent) + percent run exactly along percent chains.
    function automatic logic [N:0] close_set(input logic [N:0] a, input logic [N-1:0] p);
        logic [N:0] x;
        logic [N:0] y;
        logic [N:0] s;
        x = {1'b0, a[N-1:0] & p};
        y = {1'b0, p};
        s = x + y;
        return a | (s ^ x ^ y);
    endfunction

    always_comb begin
        count_next = count_reg;
        esc_next   = esc_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        wr_sel     = count_reg;
        wr_kind    = KIND_LITERAL;
        if (esc_enabled && data_byte == esc_char) begin
            wr_kind = KIND_LITERAL;
        end else if (data_byte == CHAR_PERCENT) begin
            wr_kind = KIND_PERCENT;
        end else if (data_byte == CHAR_UNDERSCORE) begin
            wr_kind = KIND_ANY_ONE;
        end
        if (accept) begin
            case (action)
                ACT_CLEAR: begin
                    count_next = '0;
                    esc_next   = 1'b0;
                    ovf_next   = 1'b0;
                end
                ACT_APPEND: begin
                    if (!ovf_reg) begin
                        if (esc_reg) begin
                            // The quoted byte replaces the escape stored just before it.
                            wr_en    = 1'b1;
                            wr_sel   = count_reg - CW'(1);
                            wr_kind  = KIND_LITERAL;
                            esc_next = 1'b0;
                        end else if (count_reg == CW'(N)) begin
                            ovf_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            esc_next   = esc_enabled && (data_byte == esc_char);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            kind_next[i] = kind_reg[i];
            byte_next[i] = byte_reg[i];
            if (wr_en && wr_sel == CW'(i)) begin
                kind_next[i] = wr_kind;
                byte_next[i] = data_byte;
            end
            pct_next[i] = (kind_next[i] == KIND_PERCENT) && (CW'(i) < count_next);
        end
        start_next = close_set((N+1)'(1), pct_next);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            kind_reg[i] <= kind_next[i];
            byte_reg[i] <= byte_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            esc_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            start_reg <= (N+1)'(1);
        end else begin
            count_reg <= count_next;
            esc_reg   <= esc_next;
            ovf_reg   <= ovf_next;
            start_reg <= start_next;
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            pct_mask[i]  = (kind_reg[i] == KIND_PERCENT) && (CW'(i) < count_reg);
            any_mask[i]  = (kind_reg[i] == KIND_ANY_ONE) && (CW'(i) < count_reg);
            lit_mask[i]  = (kind_reg[i] == KIND_LITERAL) && (CW'(i) < count_reg);
            elem_byte[i] = byte_reg[i];
        end
    end

    assign count     = count_reg;
    assign overflow  = ovf_reg;
    assign start_set = start_reg;

endmodule

/* sv/lwm_pos_track.sv */
// Position-set automaton: advances the active positions by one value byte per beat.
// Reads the element masks of lwm_pattern_store. Depends on lwm_pkg.
module lwm_pos_track
    import lwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  action_t               action,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic [MAX_PATTERN-1:0] pct_mask,
    input  logic [MAX_PATTERN-1:0] any_mask,
    input  logic [MAX_PATTERN-1:0] lit_mask,
    input  logic [7:0]            elem_byte [MAX_PATTERN],
    input  logic [$clog2(MAX_PATTERN+1)-1:0] count,
    input  logic                  overflow,
    input  logic [MAX_PATTERN:0]  start_set,
    output logic                  res_push,
    output result_t               res_data
);

    localparam int N = MAX_PATTERN;

    logic [N:0]   active_reg, active_next;
    logic         started_reg, started_next;
    logic [N:0]   base;
    logic [N-1:0] hit;
    logic [N-1:0] keep;
    logic [N:0]   stepped;

    function automatic logic [N:0] close_set(input logic [N:0] a, input logic [N-1:0] p);
        logic [N:0] x;
        logic [N:0] y;
        logic [N:0] s;
        x = {1'b0, a[N-1:0] & p};
        y = {1'b0, p};
        s = x + y;
        return a | (s ^ x ^ y);
    endfunction

    // The first byte of a value starts from the closed start set.
    assign base = started_reg ? active_reg : start_set;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            keep[i] = base[i] & pct_mask[i];
            hit[i]  = base[i] & (any_mask[i] | (lit_mask[i] & (elem_byte[i] == data_byte)));
        end
        stepped = close_set({hit, 1'b0} | {1'b0, keep}, pct_mask);
    end

    always_comb begin
        active_next  = active_reg;
        started_next = started_reg;
        res_push     = 1'b0;
        res_data     = '0;
        if (accept) begin
            case (action)
                ACT_VALUE: begin
                    active_next  = stepped;
                    started_next = !last_byte;
                    if (last_byte) begin
                        res_push                  = 1'b1;
                        res_data.matched          = !overflow && stepped[count];
                        res_data.pattern_overflow = overflow;
                    end
                end
                ACT_EMPTY: begin
                    started_next              = 1'b0;
                    res_push                  = 1'b1;
                    res_data.matched          = !overflow && start_set[count];
                    res_data.pattern_overflow = overflow;
                end
                default: begin
                    started_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        active_reg <= active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else begin
            started_reg <= started_next;
        end
    end

endmodule

/* sv/lwm_out_queue.sv */
// Result output register with a skid stage, so input beats keep flowing while
// one result waits. Depends on lwm_pkg.
module lwm_out_queue
    import lwm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    // A push is only offered while the skid stage is empty.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign has_room  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/like_wildcard_matcher.sv */
// Top level of the SQL LIKE matcher with escape support and APB configuration.
// Instantiates lwm_pattern_store, lwm_pos_track and lwm_out_queue; depends on lwm_pkg.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_action, s_data_byte, s_last_byte
//  m_        out        m_valid / m_ready   m_matched, m_pattern_overflow
//  apb       in         psel/penable/pready esc_en (0x0), escape_char (0x4)
//
// One input beat is taken every cycle while s_ready is high; a last value byte or an
// empty beat gives a registered result on m_valid. The position-set update for one value
// byte is a single compare stage plus one carry chain across the pattern positions.
// Reset is synchronous; no clearing pass is needed, and inputs are taken right after.
// A stalled m_ prompts one more buffered result, after which s_ready drops.
module like_wildcard_matcher
    import lwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_matched,
    output logic        m_pattern_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N  = MAX_PATTERN;
    localparam int CW = $clog2(N + 1);

    logic          esc_en_reg;
    logic [7:0]    esc_char_reg;
    logic          accept;
    action_t       action;
    logic [N-1:0]  pct_mask;
    logic [N-1:0]  any_mask;
    logic [N-1:0]  lit_mask;
    logic [7:0]    elem_byte [N];
    logic [CW-1:0] count;
    logic          overflow;
    logic [N:0]    start_set;
    logic          res_push;
    result_t       res_data;
    result_t       out_data;
    logic          has_room;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_en_reg   <= 1'b0;
            esc_char_reg <= ESC_CHAR_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ESC_ENABLED: esc_en_reg   <= pwdata[0];
                REG_ESC_CHAR:    esc_char_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ESC_ENABLED: prdata = {31'd0, esc_en_reg};
            REG_ESC_CHAR:    prdata = {24'd0, esc_char_reg};
            default:         prdata = '0;
        endcase
    end

    assign s_ready = has_room;
    assign accept  = s_valid && has_room;
    assign action  = action_t'(s_action);

    lwm_pattern_store #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (action),
        .data_byte  (s_data_byte),
        .esc_enabled(esc_en_reg),
        .esc_char   (esc_char_reg),
        .pct_mask   (pct_mask),
        .any_mask   (any_mask),
        .lit_mask   (lit_mask),
        .elem_byte  (elem_byte),
        .count      (count),
        .overflow   (overflow),
        .start_set  (start_set)
    );

    lwm_pos_track #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .action   (action),
        .data_byte(s_data_byte),
        .last_byte(s_last_byte),
        .pct_mask (pct_mask),
        .any_mask (any_mask),
        .lit_mask (lit_mask),
        .elem_byte(elem_byte),
        .count    (count),
        .overflow (overflow),
        .start_set(start_set),
        .res_push (res_push),
        .res_data (res_data)
    );

    lwm_out_queue u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .push_data(res_data),
        .has_room (has_room),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_data)
    );

    assign m_matched          = out_data.matched;
    assign m_pattern_overflow = out_data.pattern_overflow;

endmodule
